// File: rtl/core/grd_pkg.sv
// Shared types, codes and reset values for the gamepad remapper.
// Depends on nothing; every other file in rtl/core uses it.
`default_nettype none

package grd_pkg;

    // Command codes
    localparam logic [1:0] CMD_FRAME   = 2'd0;
    localparam logic [1:0] CMD_SUSPEND = 2'd1;
    localparam logic [1:0] CMD_RESUME  = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEADZONE   = 3'd0;
    localparam logic [2:0] CFG_FULL_SCALE = 3'd1;
    localparam logic [2:0] CFG_OUT_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_PANEL_W    = 3'd3;
    localparam logic [2:0] CFG_PANEL_H    = 3'd4;

    // Configuration reset values
    localparam logic [14:0] RST_DEADZONE   = 15'd15;
    localparam logic [14:0] RST_FULL_SCALE = 15'd150;
    localparam logic [6:0]  RST_OUT_LIMIT  = 7'd80;
    localparam logic [15:0] RST_PANEL_W    = 16'd320;
    localparam logic [15:0] RST_PANEL_H    = 16'd240;

    // Restoring divider: step count (one per numerator bit) and step counter width
    localparam int DIV_STEPS = 23;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DONE
    } t_top_state;

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_ADD,
        L_DIV,
        L_DONE
    } t_lane_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] keys;
        logic        touch;
        logic [15:0] col;
        logic [15:0] row;
    } t_sample;

    typedef struct packed {
        logic [31:0] prev_native;
        logic [15:0] prev_pad;
        logic        prev_touch;
        logic [15:0] kept_col;
        logic [15:0] kept_row;
        logic        susp;
        logic        await_n;
        logic [31:0] frames;
    } t_keep;

    typedef struct packed {
        logic [31:0] native_now;
        logic [31:0] native_rise;
        logic [31:0] native_fall;
        logic [15:0] pad_now;
        logic [15:0] pad_rise;
        logic [15:0] pad_fall;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
        logic [3:0]  flags;
        logic [15:0] touch_col;
        logic [15:0] touch_row;
        logic [31:0] frame_count;
    } t_result;

    typedef struct packed {
        logic [14:0] deadzone;
        logic [14:0] full_scale;
        logic [6:0]  out_limit;
    } t_stick_cfg;

    typedef struct packed {
        logic       done;
        logic [7:0] value;
    } t_lane_out;

endpackage

`default_nettype wire

// File: rtl/core/grd_axis_lane.sv
// One stick axis lane: deadzone, saturation and rounded linear scaling.
// Uses grd_pkg; a multiply step followed by a bit-serial restoring divider.
`default_nettype none

module grd_axis_lane (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [15:0]        i_axis,
    input  wire grd_pkg::t_stick_cfg i_cfg,
    output grd_pkg::t_lane_out      o_lane
);

    grd_pkg::t_lane_state r_lstate, n_lstate;

    logic [15:0]               r_mag, n_mag;
    logic                      r_neg, n_neg;
    logic [21:0]               r_prod, n_prod;
    logic [14:0]               r_range, n_range;
    logic [22:0]               r_num, n_num;
    logic [14:0]               r_rem, n_rem;
    logic [7:0]                r_quo, n_quo;
    logic [grd_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]                r_value, n_value;

    logic [15:0] trial;
    logic        fits;
    logic [14:0] diff;
    logic [7:0]  lim8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lstate <= grd_pkg::L_IDLE;
        end else begin
            r_lstate <= n_lstate;
        end
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
        r_range <= n_range;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_value <= n_value;
    end

    always_comb begin
        n_lstate = r_lstate;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_prod   = r_prod;
        n_range  = r_range;
        n_num    = r_num;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_value  = r_value;
        trial    = {r_rem, r_num[22]};
        fits     = trial >= {1'b0, r_range};
        diff     = r_mag[14:0] - i_cfg.deadzone;
        lim8     = {1'b0, i_cfg.out_limit};

        unique case (r_lstate)
            grd_pkg::L_IDLE, grd_pkg::L_DONE: begin
                if (i_start) begin
                    n_neg    = i_axis[15];
                    n_mag    = i_axis[15] ? (~i_axis + 16'd1) : i_axis;
                    n_lstate = grd_pkg::L_MUL;
                end
            end
            grd_pkg::L_MUL: begin
                if (r_mag <= {1'b0, i_cfg.deadzone}) begin
                    n_value  = 8'd0;
                    n_lstate = grd_pkg::L_DONE;
                end else if (r_mag >= {1'b0, i_cfg.full_scale}) begin
                    n_value  = r_neg ? (8'd0 - lim8) : lim8;
                    n_lstate = grd_pkg::L_DONE;
                end else begin
                    n_prod   = 22'(diff) * 22'(i_cfg.out_limit);
                    n_range  = i_cfg.full_scale - i_cfg.deadzone;
                    n_lstate = grd_pkg::L_ADD;
                end
            end
            grd_pkg::L_ADD: begin
                // add half the range for round-to-nearest
                n_num    = {1'b0, r_prod} + {9'd0, r_range[14:1]};
                n_rem    = 15'd0;
                n_quo    = 8'd0;
                n_cnt    = '0;
                n_lstate = grd_pkg::L_DIV;
            end
            grd_pkg::L_DIV: begin
                n_rem = fits ? 15'(trial - {1'b0, r_range}) : trial[14:0];
                n_num = {r_num[21:0], 1'b0};
                n_quo = {r_quo[6:0], fits};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == grd_pkg::CNT_W'(grd_pkg::DIV_STEPS - 1)) begin
                    n_value  = r_neg ? (8'd0 - n_quo) : n_quo;
                    n_lstate = grd_pkg::L_DONE;
                end
            end
            default: n_lstate = grd_pkg::L_IDLE;
        endcase
    end

    assign o_lane.done  = (r_lstate == grd_pkg::L_DONE);
    assign o_lane.value = r_value;

endmodule

`default_nettype wire

// File: rtl/core/grd_merge.sv
// Merge stage: key remap, edge masks, touch clamp, suspend/wait handling.
// Uses grd_pkg; combines the two axis lane results with the held state.
`default_nettype none

module grd_merge (
    input  wire grd_pkg::t_sample i_smp,
    input  wire grd_pkg::t_keep   i_keep,
    input  wire logic [7:0]       i_sx,
    input  wire logic [7:0]       i_sy,
    input  wire logic [15:0]      i_panel_w,
    input  wire logic [15:0]      i_panel_h,
    output grd_pkg::t_result      o_res,
    output grd_pkg::t_keep        o_keep
);

    function automatic logic [15:0] remap_keys(input logic [31:0] k);
        logic [15:0] p;
        logic        up, dn, lf, rt;
        p  = 16'd0;
        up = k[6] & ~k[7];
        dn = k[7] & ~k[6];
        lf = k[5] & ~k[4];
        rt = k[4] & ~k[5];
        p[15] = k[0];
        p[14] = k[1];
        p[13] = k[10] | k[14];
        p[12] = k[3];
        p[4]  = k[8] | k[15];
        if (k[9] && (up || dn || lf || rt)) begin
            p[11:8] = {up, dn, lf, rt};
        end else begin
            p[5]   = k[9];
            p[3:0] = {up, dn, lf, rt};
        end
        p[3] = p[3] | k[26];
        p[2] = p[2] | k[27] | k[11];
        p[1] = p[1] | k[25];
        p[0] = p[0] | k[24];
        return p;
    endfunction

    function automatic logic [15:0] clamp(input logic [15:0] v, input logic [15:0] lim);
        return (v >= lim) ? (lim - 16'd1) : v;
    endfunction

    logic [15:0] pad;
    logic [31:0] rise;

    always_comb begin
        o_keep = i_keep;
        o_res  = '0;
        pad    = remap_keys(i_smp.keys);
        rise   = i_smp.keys & ~i_keep.prev_native;

        if (i_smp.cmd == grd_pkg::CMD_SUSPEND || i_smp.cmd == grd_pkg::CMD_RESUME) begin
            o_keep.prev_native = '0;
            o_keep.prev_pad    = '0;
            o_keep.prev_touch  = 1'b0;
            o_keep.susp        = (i_smp.cmd == grd_pkg::CMD_SUSPEND);
            o_keep.await_n     = 1'b1;
        end else begin
            o_keep.frames = i_keep.frames + 32'd1;
            if (i_keep.susp || i_keep.await_n) begin
                // leave the wait only on a fully neutral sample
                if (!i_keep.susp && i_smp.keys == 32'd0 && !i_smp.touch
                    && i_sx == 8'd0 && i_sy == 8'd0) begin
                    o_keep.await_n = 1'b0;
                end
                o_keep.prev_native = '0;
                o_keep.prev_pad    = '0;
                o_keep.prev_touch  = 1'b0;
            end else begin
                o_res.native_now  = i_smp.keys;
                o_res.native_rise = rise;
                o_res.native_fall = i_keep.prev_native & ~i_smp.keys;
                o_res.pad_now     = pad;
                o_res.pad_rise    = pad & ~i_keep.prev_pad;
                o_res.pad_fall    = i_keep.prev_pad & ~pad;
                o_res.stick_x     = i_sx;
                o_res.stick_y     = i_sy;
                o_res.flags       = {rise[2],
                                     ~i_smp.touch & i_keep.prev_touch,
                                     i_smp.touch & ~i_keep.prev_touch,
                                     i_smp.touch};
                if (i_smp.touch) begin
                    o_keep.kept_col = clamp(i_smp.col, i_panel_w);
                    o_keep.kept_row = clamp(i_smp.row, i_panel_h);
                end
                o_keep.prev_native = i_smp.keys;
                o_keep.prev_pad    = pad;
                o_keep.prev_touch  = i_smp.touch;
            end
        end

        o_res.touch_col   = o_keep.kept_col;
        o_res.touch_row   = o_keep.kept_row;
        o_res.frame_count = o_keep.frames;
    end

endmodule

`default_nettype wire

// File: rtl/core/gamepad_remap_edge_deadzone.sv
// Top level of the gamepad remapper: request capture, control FSM, state.
// Depends on grd_pkg, grd_axis_lane (two lanes) and grd_merge.
//
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     command, keys, axes, touch
// result    out        o_out_valid / i_out_ready   key masks, pad, stick, touch, count
// config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// A request with an axis that needs stick scaling runs through the 23-step restoring
// divider of that axis lane before the next accept. A request whose axes fall in the
// deadzone or saturate skips the divider.
// Command code 3 is dropped at accept and gives no result.
// The finished result sits in an output register, so a new request is taken while it
// waits; the next result is held in the FSM until the output register frees up.
// Reset is synchronous, active low, clears the FSM, valid flag and held state, and
// loads the configuration registers with their reset values.
`default_nettype none

module gamepad_remap_edge_deadzone (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_command,
    input  wire logic [31:0]       i_keys_held,
    input  wire logic signed [15:0] i_axis_x,
    input  wire logic signed [15:0] i_axis_y,
    input  wire logic              i_touch_active,
    input  wire logic [15:0]       i_touch_col,
    input  wire logic [15:0]       i_touch_row,

    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [31:0]            o_native_now,
    output logic [31:0]            o_native_rise,
    output logic [31:0]            o_native_fall,
    output logic [15:0]            o_pad_now,
    output logic [15:0]            o_pad_rise,
    output logic [15:0]            o_pad_fall,
    output logic signed [7:0]      o_stick_out_x,
    output logic signed [7:0]      o_stick_out_y,
    output logic [3:0]             o_status_flags,
    output logic [15:0]            o_touch_out_col,
    output logic [15:0]            o_touch_out_row,
    output logic [31:0]            o_frame_count,

    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data
);

    grd_pkg::t_top_state r_state, n_state;

    // configuration registers
    logic [14:0] r_deadzone;
    logic [14:0] r_full_scale;
    logic [6:0]  r_out_limit;
    logic [15:0] r_panel_w;
    logic [15:0] r_panel_h;

    grd_pkg::t_sample   r_smp;
    grd_pkg::t_keep     r_keep;
    grd_pkg::t_result   r_out;
    logic               r_out_valid;

    grd_pkg::t_keep     keep_next;
    grd_pkg::t_result   res_next;
    grd_pkg::t_stick_cfg stick_cfg;
    grd_pkg::t_lane_out lane_x, lane_y;

    logic accept;
    logic lane_start;
    logic commit;

    assign accept     = i_in_valid && o_in_ready;
    assign lane_start = accept && (i_command != grd_pkg::CMD_UNUSED);

    assign stick_cfg.deadzone   = r_deadzone;
    assign stick_cfg.full_scale = r_full_scale;
    assign stick_cfg.out_limit  = r_out_limit;

    // Write configuration; the user must write only while idle, the block has no guard against live requests.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone   <= grd_pkg::RST_DEADZONE;
            r_full_scale <= grd_pkg::RST_FULL_SCALE;
            r_out_limit  <= grd_pkg::RST_OUT_LIMIT;
            r_panel_w    <= grd_pkg::RST_PANEL_W;
            r_panel_h    <= grd_pkg::RST_PANEL_H;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                grd_pkg::CFG_DEADZONE:   r_deadzone   <= i_cfg_data[14:0];
                grd_pkg::CFG_FULL_SCALE: r_full_scale <= i_cfg_data[14:0];
                grd_pkg::CFG_OUT_LIMIT:  r_out_limit  <= i_cfg_data[6:0];
                grd_pkg::CFG_PANEL_W:    r_panel_w    <= i_cfg_data;
                grd_pkg::CFG_PANEL_H:    r_panel_h    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the request payload while the lanes work on it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp.cmd   <= i_command;
            r_smp.keys  <= i_keys_held;
            r_smp.touch <= i_touch_active;
            r_smp.col   <= i_touch_col;
            r_smp.row   <= i_touch_row;
        end
    end

    grd_axis_lane u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_axis  (i_axis_x),
        .i_cfg   (stick_cfg),
        .o_lane  (lane_x)
    );

    grd_axis_lane u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_axis  (i_axis_y),
        .i_cfg   (stick_cfg),
        .o_lane  (lane_y)
    );

    grd_merge u_merge (
        .i_smp     (r_smp),
        .i_keep    (r_keep),
        .i_sx      (lane_x.value),
        .i_sy      (lane_y.value),
        .i_panel_w (r_panel_w),
        .i_panel_h (r_panel_h),
        .o_res     (res_next),
        .o_keep    (keep_next)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: take a request, wait for both lanes, then commit once the
    // output register is free.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            grd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (lane_start) begin
                    n_state = grd_pkg::S_CALC;
                end
            end
            grd_pkg::S_CALC: begin
                if (lane_x.done && lane_y.done) begin
                    n_state = grd_pkg::S_DONE;
                end
            end
            grd_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    commit  = 1'b1;
                    n_state = grd_pkg::S_IDLE;
                end
            end
            default: n_state = grd_pkg::S_IDLE;
        endcase
    end

    // Advance the held state and load the output register on commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_keep      <= keep_next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= res_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_native_now    = r_out.native_now;
    assign o_native_rise   = r_out.native_rise;
    assign o_native_fall   = r_out.native_fall;
    assign o_pad_now       = r_out.pad_now;
    assign o_pad_rise      = r_out.pad_rise;
    assign o_pad_fall      = r_out.pad_fall;
    assign o_stick_out_x   = r_out.stick_x;
    assign o_stick_out_y   = r_out.stick_y;
    assign o_status_flags  = r_out.flags;
    assign o_touch_out_col = r_out.touch_col;
    assign o_touch_out_row = r_out.touch_row;
    assign o_frame_count   = r_out.frame_count;

`ifndef SYNTH
    // commit only with both lane results in hand
    a_lanes_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == grd_pkg::S_DONE) |-> (lane_x.done && lane_y.done))
        else $error("commit state reached with a lane still busy");

    // frame count moves only on a committed frame sample
    a_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_keep.frames) |-> $past(commit && r_smp.cmd == grd_pkg::CMD_FRAME))
        else $error("frame count changed without a frame commit");

    // live history stays cleared while suspended or waiting for neutral
    a_live_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_keep.susp || r_keep.await_n) |->
        (r_keep.prev_native == 32'd0 && r_keep.prev_pad == 16'd0 && !r_keep.prev_touch))
        else $error("live state not cleared while suspended or waiting");

    // a new result appears only out of the commit state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == grd_pkg::S_DONE))
        else $error("result valid raised outside commit");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for gamepad_remap_edge_deadzone: key remap, edges, stick scaling,
// touch clamping and suspend/resume, checked against an in-bench predictor.
// Depends on grd_pkg and the gamepad_remap_edge_deadzone top level only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Known native key bits; the rest of the word is passed through untouched
    localparam logic [31:0] KEY_MASK  = 32'h0F10_CFFF;
    // D-pad directions plus L, the keys that steer the target D-pad
    localparam logic [31:0] DPAD_L    = 32'h0000_02F0;
    localparam int          SETTLE    = 40;
    localparam int          IDLE_STOP = 3000;  // cycles with no handshake before giving up

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_BURSTY} t_rdy_mode;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] keys;
        logic [15:0] ax;
        logic [15:0] ay;
        logic        touch;
        logic [15:0] col;
        logic [15:0] row;
    } t_pad_req;

    // ---------------------------------------------------------------- DUT ports
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_command      = grd_pkg::CMD_FRAME;
    logic [31:0] i_keys_held    = '0;
    logic [15:0] i_axis_x       = '0;
    logic [15:0] i_axis_y       = '0;
    logic        i_touch_active = 1'b0;
    logic [15:0] i_touch_col    = '0;
    logic [15:0] i_touch_row    = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [31:0] o_native_now, o_native_rise, o_native_fall;
    logic [15:0] o_pad_now, o_pad_rise, o_pad_fall;
    logic signed [7:0] o_stick_out_x, o_stick_out_y;
    logic [3:0]  o_status_flags;
    logic [15:0] o_touch_out_col, o_touch_out_row;
    logic [31:0] o_frame_count;
    logic        i_cfg_we       = 1'b0;
    logic [2:0]  i_cfg_index    = grd_pkg::CFG_DEADZONE;
    logic [15:0] i_cfg_data     = '0;

    // ---------------------------------------------------------- predictor state
    logic [14:0] cfg_deadzone   = grd_pkg::RST_DEADZONE;
    logic [14:0] cfg_full_scale = grd_pkg::RST_FULL_SCALE;
    logic [6:0]  cfg_out_limit  = grd_pkg::RST_OUT_LIMIT;
    logic [15:0] cfg_panel_w    = grd_pkg::RST_PANEL_W;
    logic [15:0] cfg_panel_h    = grd_pkg::RST_PANEL_H;

    logic [31:0] hist_native = '0;
    logic [15:0] hist_pad    = '0;
    logic        hist_touch  = 1'b0;
    logic [15:0] held_col    = '0;
    logic [15:0] held_row    = '0;
    logic        suspended   = 1'b0;
    logic        await_idle  = 1'b0;
    logic [31:0] frame_total = '0;

    grd_pkg::t_result expected_reports[$];
    int          mismatch_count = 0;
    int          reports_seen   = 0;

    // ------------------------------------------------------------ pacing knobs
    t_rdy_mode   ready_mode = RDY_ALWAYS;
    int          gap_max    = 0;
    int          burst_left = 0;
    int          hold_left  = 0;
    logic [31:0] last_keys  = '0;

    gamepad_remap_edge_deadzone u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_keys_held     (i_keys_held),
        .i_axis_x        (i_axis_x),
        .i_axis_y        (i_axis_y),
        .i_touch_active  (i_touch_active),
        .i_touch_col     (i_touch_col),
        .i_touch_row     (i_touch_row),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_native_now    (o_native_now),
        .o_native_rise   (o_native_rise),
        .o_native_fall   (o_native_fall),
        .o_pad_now       (o_pad_now),
        .o_pad_rise      (o_pad_rise),
        .o_pad_fall      (o_pad_fall),
        .o_stick_out_x   (o_stick_out_x),
        .o_stick_out_y   (o_stick_out_y),
        .o_status_flags  (o_status_flags),
        .o_touch_out_col (o_touch_out_col),
        .o_touch_out_row (o_touch_out_row),
        .o_frame_count   (o_frame_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ============================================================== predictor

    // Native keys to the 16-bit target pad word
    function automatic logic [15:0] remap_pad(input logic [31:0] k);
        logic [15:0] p;
        logic up, dn, lf, rt;
        up = k[6];
        dn = k[7];
        lf = k[5];
        rt = k[4];
        // opposite directions cancel each other
        if (up && dn) begin
            up = 1'b0;
            dn = 1'b0;
        end
        if (lf && rt) begin
            lf = 1'b0;
            rt = 1'b0;
        end
        p = '0;
        p[15] = k[0];
        p[14] = k[1];
        p[13] = k[10] | k[14];
        p[12] = k[3];
        p[4]  = k[8] | k[15];
        p[2]  = k[11];
        // L with a live D-pad steers the target D-pad and is swallowed;
        // otherwise the D-pad lands on the C buttons
        if (k[9] && (up | dn | lf | rt)) begin
            p[11:8] = {up, dn, lf, rt};
        end else begin
            p[5]   = k[9];
            p[3:0] = p[3:0] | {up, dn, lf, rt};
        end
        p[3:0] = p[3:0] | {k[26], k[27], k[25], k[24]};
        return p;
    endfunction

    // Deadzone, saturation and rounded linear scaling of one axis
    function automatic logic [7:0] scale_stick(input logic [15:0] raw);
        logic [31:0] mag, span, s;
        mag = raw[15] ? (32'h1_0000 - {16'h0, raw}) : {16'h0, raw};
        if (mag <= {17'h0, cfg_deadzone})
            return 8'h00;
        if (mag >= {17'h0, cfg_full_scale}) begin
            s = {25'h0, cfg_out_limit};
        end else begin
            span = {17'h0, cfg_full_scale} - {17'h0, cfg_deadzone};
            s = ((mag - {17'h0, cfg_deadzone}) * {25'h0, cfg_out_limit} + span / 2) / span;
        end
        if (raw[15])
            s = 32'h0 - s;
        return s[7:0];
    endfunction

    // A panel size of zero wraps to the top of the range
    function automatic logic [15:0] clamp_touch(input logic [15:0] v, input logic [15:0] lim);
        if (v >= lim)
            return lim - 16'd1;
        return v;
    endfunction

    function automatic void forget_held();
        hist_native = '0;
        hist_pad    = '0;
        hist_touch  = 1'b0;
    endfunction

    // Advance the predicted state by one request; returns 0 when no report follows
    function automatic bit compute_report(input t_pad_req r, output grd_pkg::t_result res);
        logic [7:0] sx, sy;
        res = '0;
        sx  = '0;
        sy  = '0;
        if (r.cmd == grd_pkg::CMD_UNUSED)
            return 1'b0;
        if (r.cmd == grd_pkg::CMD_SUSPEND || r.cmd == grd_pkg::CMD_RESUME) begin
            forget_held();
            suspended  = (r.cmd == grd_pkg::CMD_SUSPEND);
            await_idle = 1'b1;
        end else begin
            frame_total = frame_total + 32'd1;
            if (suspended) begin
                forget_held();
            end else begin
                sx = scale_stick(r.ax);
                sy = scale_stick(r.ay);
                if (await_idle) begin
                    // only an all-neutral sample releases the hold; it still reports cleared
                    if (r.keys == '0 && !r.touch && sx == '0 && sy == '0)
                        await_idle = 1'b0;
                    forget_held();
                    sx = '0;
                    sy = '0;
                end else begin
                    res.native_now  = r.keys;
                    res.native_rise = r.keys & ~hist_native;
                    res.native_fall = hist_native & ~r.keys;
                    res.pad_now     = remap_pad(r.keys);
                    res.pad_rise    = res.pad_now & ~hist_pad;
                    res.pad_fall    = hist_pad & ~res.pad_now;
                    res.flags       = {res.native_rise[2], !r.touch && hist_touch,
                                       r.touch && !hist_touch, r.touch};
                    if (r.touch) begin
                        held_col = clamp_touch(r.col, cfg_panel_w);
                        held_row = clamp_touch(r.row, cfg_panel_h);
                    end
                    hist_native = r.keys;
                    hist_pad    = res.pad_now;
                    hist_touch  = r.touch;
                end
            end
        end
        res.stick_x     = sx;
        res.stick_y     = sy;
        res.touch_col   = held_col;
        res.touch_row   = held_row;
        res.frame_count = frame_total;
        return 1'b1;
    endfunction

    // ============================================================== checking

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("report %0d %s: expected %h, got %h", reports_seen, name, want, got);
        end
    endtask

    // Compare each report first, then predict the request taken on the same edge
    always @(posedge i_clk) begin
        grd_pkg::t_result got, want;
        t_pad_req req;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.native_now  = o_native_now;
                got.native_rise = o_native_rise;
                got.native_fall = o_native_fall;
                got.pad_now     = o_pad_now;
                got.pad_rise    = o_pad_rise;
                got.pad_fall    = o_pad_fall;
                got.stick_x     = o_stick_out_x;
                got.stick_y     = o_stick_out_y;
                got.flags       = o_status_flags;
                got.touch_col   = o_touch_out_col;
                got.touch_row   = o_touch_out_row;
                got.frame_count = o_frame_count;
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("report %0d arrived with nothing pending", reports_seen);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("native_now",    want.native_now,  got.native_now);
                    check_field("native_rise",   want.native_rise, got.native_rise);
                    check_field("native_fall",   want.native_fall, got.native_fall);
                    check_field("pad_now",       want.pad_now,     got.pad_now);
                    check_field("pad_rise",      want.pad_rise,    got.pad_rise);
                    check_field("pad_fall",      want.pad_fall,    got.pad_fall);
                    check_field("stick_out_x",   want.stick_x,     got.stick_x);
                    check_field("stick_out_y",   want.stick_y,     got.stick_y);
                    check_field("status_flags",  want.flags,       got.flags);
                    check_field("touch_out_col", want.touch_col,   got.touch_col);
                    check_field("touch_out_row", want.touch_row,   got.touch_row);
                    check_field("frame_count",   want.frame_count, got.frame_count);
                end
                reports_seen++;
            end
            if (i_in_valid && o_in_ready) begin
                req = {i_command, i_keys_held, i_axis_x, i_axis_y,
                       i_touch_active, i_touch_col, i_touch_row};
                if (compute_report(req, want))
                    expected_reports.push_back(want);
            end
        end
    end

    // ============================================================ result side

    // Stall the report channel: always ready, coin flips, or long on/off stretches
    always @(negedge i_clk) begin
        case (ready_mode)
            RDY_ALWAYS: i_out_ready = 1'b1;
            RDY_COIN:   i_out_ready = 1'($urandom_range(0, 1));
            default: begin
                if (hold_left == 0) begin
                    i_out_ready = ~i_out_ready;
                    hold_left   = i_out_ready ? $urandom_range(1, 20) : $urandom_range(1, 60);
                end else begin
                    hold_left--;
                end
            end
        endcase
    end

    // Stop the run when neither channel has moved for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_STOP) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[gamepad_remap_edge_deadzone] ERROR");
        $finish;
    end

    // ============================================================ request side

    // Send one request in bursts; hold the payload until it is taken.
    // Call and return at a falling edge.
    task automatic send_request(input t_pad_req r);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_command      = r.cmd;
        i_keys_held    = r.keys;
        i_axis_x       = r.ax;
        i_axis_y       = r.ay;
        i_touch_active = r.touch;
        i_touch_col    = r.col;
        i_touch_row    = r.row;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every pending report, then let the block go quiet
    task automatic settle_idle();
        i_in_valid = 1'b0;
        while (expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        case (idx)
            grd_pkg::CFG_DEADZONE:   cfg_deadzone   = val[14:0];
            grd_pkg::CFG_FULL_SCALE: cfg_full_scale = val[14:0];
            grd_pkg::CFG_OUT_LIMIT:  cfg_out_limit  = val[6:0];
            grd_pkg::CFG_PANEL_W:    cfg_panel_w    = val;
            grd_pkg::CFG_PANEL_H:    cfg_panel_h    = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic apply_config(input int dz, input int fs, input int lim,
                                input int pw, input int ph);
        settle_idle();
        write_reg(grd_pkg::CFG_DEADZONE,   16'(dz));
        write_reg(grd_pkg::CFG_FULL_SCALE, 16'(fs));
        write_reg(grd_pkg::CFG_OUT_LIMIT,  16'(lim));
        write_reg(grd_pkg::CFG_PANEL_W,    16'(pw));
        write_reg(grd_pkg::CFG_PANEL_H,    16'(ph));
    endtask

    task automatic set_pace(input t_rdy_mode mode, input int gaps);
        ready_mode = mode;
        gap_max    = gaps;
    endtask

    function automatic t_pad_req frame_req(input logic [31:0] keys, input logic [15:0] ax,
                                           input logic [15:0] ay, input logic touch,
                                           input logic [15:0] col, input logic [15:0] row);
        return {grd_pkg::CMD_FRAME, keys, ax, ay, touch, col, row};
    endfunction

    // Non-frame command with a junk payload
    function automatic t_pad_req cmd_req(input logic [1:0] c);
        logic [31:0] a, b;
        a = $urandom();
        b = $urandom();
        return {c, $urandom(), a[15:0], a[31:16], b[0], b[15:0], b[31:16]};
    endfunction

    // ------------------------------------------------------- random content

    function automatic logic [31:0] pick_keys();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0:       k = '0;
            1, 2:    k = $urandom();
            3, 4:    k = $urandom() & KEY_MASK;
            5:       k = ($urandom() & DPAD_L) | ($urandom() & $urandom() & KEY_MASK);
            6, 7:    k = last_keys;
            8:       k = last_keys ^ (32'h1 << $urandom_range(0, 31));
            default: k = $urandom() & $urandom() & KEY_MASK;
        endcase
        last_keys = k;
        return k;
    endfunction

    function automatic logic [15:0] pick_axis();
        int          mag;
        logic [31:0] w;
        logic [15:0] v;
        w = $urandom();
        case ($urandom_range(0, 11))
            0:       mag = 0;
            1:       mag = cfg_deadzone;
            2:       mag = cfg_deadzone + 1;
            3:       mag = cfg_full_scale - 1;
            4:       mag = cfg_full_scale;
            5, 6, 7: mag = $urandom_range(cfg_deadzone, cfg_full_scale);
            8:       return w[15:0];
            9:       return w[16] ? 16'h8000 : 16'h7FFF;
            default: mag = $urandom_range(0, 32767);
        endcase
        if (mag > 32767)
            mag = 32767;
        v = mag[15:0];
        return w[0] ? -v : v;
    endfunction

    // Axis that scales to zero under the current deadzone
    function automatic logic [15:0] quiet_axis();
        logic [15:0] v;
        v = 16'($urandom_range(0, cfg_deadzone));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [15:0] pick_coord(input logic [15:0] lim);
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 5))
            0, 1:    return w[15:0];
            2:       return lim - 16'd1;
            3:       return lim;
            default: return 16'($urandom_range(0, lim));
        endcase
    endfunction

    // Mostly well-formed sessions: while held after suspend/resume, lean on neutral
    // samples so the hold is released and live traffic follows
    function automatic t_pad_req pick_request();
        t_pad_req r;
        int       roll;
        r = frame_req(pick_keys(), pick_axis(), pick_axis(), 1'($urandom_range(0, 1)),
                      pick_coord(cfg_panel_w), pick_coord(cfg_panel_h));
        roll = $urandom_range(0, 99);
        if (suspended) begin
            if (roll < 30)
                r = cmd_req(grd_pkg::CMD_RESUME);
        end else if (await_idle) begin
            if (roll < 55) begin
                r.keys  = '0;
                r.touch = 1'b0;
                r.ax    = quiet_axis();
                r.ay    = quiet_axis();
            end else if (roll < 60) begin
                r = cmd_req(grd_pkg::CMD_SUSPEND);
            end
        end else begin
            if (roll < 3)
                r = cmd_req(grd_pkg::CMD_SUSPEND);
            else if (roll < 6)
                r = cmd_req(grd_pkg::CMD_RESUME);
            else if (roll < 8)
                r = cmd_req(grd_pkg::CMD_UNUSED);
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_request(pick_request());
    endtask

    // ================================================================= tests

    // Remap rules, edges, touch clamping and the menu request at reset settings
    task automatic test_key_mapping();
        set_pace(RDY_ALWAYS, 0);
        send_request(frame_req(32'h0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0));
        // A, Select, Start with a fresh touch: touch pressed and menu raised
        send_request(frame_req(32'h0000_000D, 16'h0, 16'h0, 1'b1, 16'd5, 16'd7));
        // every bit held, touch far off the panel
        send_request(frame_req(32'hFFFF_FFFF, 16'h0, 16'h0, 1'b1, 16'hFFFF, 16'hFFFF));
        // up and down cancel, left survives onto the C buttons
        send_request(frame_req(32'h0000_00E0, 16'h0, 16'h0, 1'b1, 16'd319, 16'd239));
        // L with up and right drives the target D-pad, L itself is swallowed
        send_request(frame_req(32'h0000_0250, 16'h0, 16'h0, 1'b1, 16'd320, 16'd240));
        // L with a cancelled pair counts as no D-pad, so L passes
        send_request(frame_req(32'h0000_02C0, 16'h0, 16'h0, 1'b0, 16'd1, 16'd1));
        // C-stick, B, R, X, Y, ZL, ZR and the native touch bit
        send_request(frame_req(32'h0F10_CD02, 16'h0, 16'h0, 1'b0, 16'd9, 16'd9));
        // release everything
        send_request(frame_req(32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 16'd0));
    endtask

    // Axis magnitudes on both sides of the deadzone and the full-scale point
    task automatic test_stick_deadzone();
        set_pace(RDY_ALWAYS, 0);
        send_request(frame_req(32'h0, 16'd15, -16'd15, 1'b0, 16'h0, 16'h0));
        send_request(frame_req(32'h0, 16'd16, -16'd16, 1'b0, 16'h0, 16'h0));
        send_request(frame_req(32'h0, 16'd149, -16'd149, 1'b0, 16'h0, 16'h0));
        send_request(frame_req(32'h0, 16'd150, -16'd150, 1'b0, 16'h0, 16'h0));
        send_request(frame_req(32'h0, 16'h7FFF, 16'h8000, 1'b0, 16'h0, 16'h0));
        send_request(frame_req(32'h0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0));
    endtask

    // Suspend, resume, the dropped command code and the neutral-sample release
    task automatic test_suspend_resume();
        set_pace(RDY_ALWAYS, 0);
        send_request(cmd_req(grd_pkg::CMD_SUSPEND));
        // frames while suspended still count
        send_request(frame_req(32'h0000_0001, 16'd500, 16'd500, 1'b1, 16'd3, 16'd3));
        send_request(cmd_req(grd_pkg::CMD_UNUSED));
        send_request(cmd_req(grd_pkg::CMD_RESUME));
        // a held key keeps the outputs cleared
        send_request(frame_req(32'h0000_0001, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0));
        // inside the deadzone only: neutral, releases the hold but reports cleared
        send_request(frame_req(32'h0, 16'd10, -16'd10, 1'b0, 16'd4, 16'd4));
        send_request(frame_req(32'h0000_0004, 16'd80, -16'd80, 1'b1, 16'd11, 16'd12));
        send_request(cmd_req(grd_pkg::CMD_SUSPEND));
        send_request(cmd_req(grd_pkg::CMD_RESUME));
        send_request(frame_req(32'h0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0));
        send_request(frame_req(32'h0000_0004, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0));
    endtask

    // Random sessions at reset settings under every pacing style
    task automatic test_random_traffic();
        set_pace(RDY_ALWAYS, 0);
        run_random(80);
        set_pace(RDY_COIN, 6);
        run_random(80);
        set_pace(RDY_BURSTY, 40);
        run_random(80);
    endtask

    // Register extremes: widest range, inverted deadzone, unit panel, zero panel
    task automatic test_config_extremes();
        apply_config(0, 32767, 127, 65535, 65535);
        set_pace(RDY_COIN, 10);
        run_random(60);
        apply_config(32766, 1, 0, 0, 0);
        set_pace(RDY_BURSTY, 20);
        run_random(60);
        apply_config(0, 1, 127, 1, 1);
        set_pace(RDY_ALWAYS, 0);
        run_random(60);
        apply_config(100, 4000, 127, 1024, 600);
        set_pace(RDY_COIN, 25);
        run_random(100);
    endtask

    task automatic test_random_configs();
        int dz, fs, pw, ph;
        repeat (5) begin
            dz = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 32766);
            fs = dz + $urandom_range(1, 4000);
            if (fs > 32767)
                fs = 32767;
            pw = $urandom_range(0, 1) ? $urandom_range(1, 2048) : $urandom_range(0, 65535);
            ph = $urandom_range(0, 1) ? $urandom_range(1, 2048) : $urandom_range(0, 65535);
            apply_config(dz, fs, $urandom_range(0, 127), pw, ph);
            set_pace(t_rdy_mode'($urandom_range(0, 2)), $urandom_range(0, 30));
            run_random(60);
        end
    endtask

    // ================================================================ sequence

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_key_mapping();
        test_stick_deadzone();
        test_suspend_resume();
        test_random_traffic();
        test_config_extremes();
        test_random_configs();

        settle_idle();
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("[gamepad_remap_edge_deadzone] OK");
        else
            $display("[gamepad_remap_edge_deadzone] ERROR");
        $finish;
    end

endmodule
